// ===== design/hecc_pkg.sv =====
// shared constants, types and helper functions for the hamming ecc engine
`timescale 1ns / 1ps
`default_nettype none

package hecc_pkg;

    localparam int MAX_BLOCK_LOG2 = 9;
    localparam int ADDR_W         = 9;
    localparam int CODE_W         = 24;
    localparam int LOG2_W         = 4;
    localparam int STATUS_W       = 2;
    localparam int BIT_W          = 3;

    localparam logic [LOG2_W-1:0] LOG2_RESET = LOG2_W'(MAX_BLOCK_LOG2);
    localparam logic [LOG2_W-1:0] LOG2_MAX   = LOG2_W'(MAX_BLOCK_LOG2);

    // even positions of the code: first member of every parity pair
    localparam logic [CODE_W-1:0] PAIR_EVEN = 24'h555555;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FIXED    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_CODE_ERR = 2'd2;
    localparam logic [STATUS_W-1:0] ST_UNCORR   = 2'd3;

    // one finished block on its way to the checker
    typedef struct packed {
        logic [CODE_W-1:0] gen;
        logic [CODE_W-1:0] stored;
        logic [CODE_W-1:0] mask;
    } hecc_blk_t;

    function automatic logic par8(input logic [7:0] v);
        par8 = ^v;
    endfunction

    // code width is 2*(k+3) bits
    function automatic logic [CODE_W-1:0] code_mask(input logic [LOG2_W-1:0] k);
        logic [CODE_W-1:0] m;
        logic [5:0]        w;
        w = 6'(2 * (int'(k) + 3));
        for (int i = 0; i < CODE_W; i++)
        begin
            m[i] = (6'(i) < w);
        end
        code_mask = m;
    endfunction

    // last byte address of a block of 2^k bytes
    function automatic logic [ADDR_W-1:0] last_addr(input logic [LOG2_W-1:0] k);
        logic [ADDR_W-1:0] a;
        for (int i = 0; i < ADDR_W; i++)
        begin
            a[i] = (LOG2_W'(i) < k);
        end
        last_addr = a;
    endfunction

endpackage

`default_nettype wire

// ===== design/hecc_accum.sv =====
// parity accumulation over a block, block length register and finished-block register
`timescale 1ns / 1ps
`default_nettype none

module hecc_accum
    import hecc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [LOG2_W-1:0]     block_bytes_log2,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [7:0]            data_byte,
    input  wire logic [CODE_W-1:0]     stored_code,
    input  wire logic                  chk_take,
    output logic                       chk_valid,
    output hecc_blk_t                  chk_blk
);

    logic [LOG2_W-1:0] k_reg;
    logic [LOG2_W-1:0] k_next;
    logic [CODE_W-1:0] acc_reg;
    logic [CODE_W-1:0] acc_next;
    logic [ADDR_W-1:0] pos_reg;
    logic [ADDR_W-1:0] pos_next;
    logic              chk_valid_reg;
    logic              chk_valid_next;
    hecc_blk_t         blk_reg;
    hecc_blk_t         blk_next;

    logic              cfg_fire;
    logic              in_fire;
    logic              is_final;
    logic [ADDR_W-1:0] last;
    logic [CODE_W-1:0] mask;
    logic [CODE_W-1:0] contrib;
    logic [CODE_W-1:0] acc_sum;
    logic              rp;

    assign cfg_ready = ~chk_valid_reg;
    assign cfg_fire  = cfg_valid & cfg_ready;
    assign in_stall  = chk_valid_reg & ~chk_take;
    assign in_fire   = in_valid & ~in_stall;

    assign last     = last_addr(k_reg);
    assign mask     = code_mask(k_reg);
    assign is_final = (pos_reg >= last);
    assign rp       = par8(data_byte);

    always_comb
    begin
        contrib    = '0;
        contrib[0] = par8(data_byte & 8'h55);
        contrib[1] = par8(data_byte & 8'hAA);
        contrib[2] = par8(data_byte & 8'h33);
        contrib[3] = par8(data_byte & 8'hCC);
        contrib[4] = par8(data_byte & 8'h0F);
        contrib[5] = par8(data_byte & 8'hF0);
        // row pair j: odd member when address bit j is set
        for (int j = 0; j < ADDR_W; j++)
        begin
            contrib[6 + 2*j] = rp & (LOG2_W'(j) < k_reg) & ~pos_reg[j];
            contrib[7 + 2*j] = rp & (LOG2_W'(j) < k_reg) & pos_reg[j];
        end
    end

    assign acc_sum = acc_reg ^ contrib;

    always_comb
    begin
        k_next         = k_reg;
        acc_next       = acc_reg;
        pos_next       = pos_reg;
        chk_valid_next = chk_valid_reg;
        blk_next       = blk_reg;
        if (cfg_fire)
        begin
            k_next   = (block_bytes_log2 > LOG2_MAX) ? LOG2_MAX : block_bytes_log2;
            acc_next = '0;
            pos_next = '0;
        end
        else if (in_fire)
        begin
            if (is_final)
            begin
                acc_next = '0;
                pos_next = '0;
            end
            else
            begin
                acc_next = acc_sum;
                pos_next = pos_reg + ADDR_W'(1);
            end
        end
        // finished-block register is free when empty or drained this cycle
        if (!in_stall)
        begin
            chk_valid_next = in_fire & is_final & ~cfg_fire;
            blk_next.gen    = acc_sum & mask;
            blk_next.stored = stored_code & mask;
            blk_next.mask   = mask;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= LOG2_RESET;
            acc_reg       <= '0;
            pos_reg       <= '0;
            chk_valid_reg <= 1'b0;
        end
        else
        begin
            k_reg         <= k_next;
            acc_reg       <= acc_next;
            pos_reg       <= pos_next;
            chk_valid_reg <= chk_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
    end

    assign chk_valid = chk_valid_reg;
    assign chk_blk   = blk_reg;

    a_pos_in_block: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= last)
        else $error("byte position past end of block");

    a_final_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && is_final && !cfg_fire) |=> chk_valid_reg)
        else $error("final byte did not produce a block");

    a_gen_masked: assert property (@(posedge clk) disable iff (!rst_n)
        chk_valid_reg |-> ((blk_reg.gen & ~blk_reg.mask) == '0))
        else $error("generated code has bits above code width");

    a_k_sat: assert property (@(posedge clk) disable iff (!rst_n)
        k_reg <= LOG2_MAX)
        else $error("block log2 not saturated");

endmodule

`default_nettype wire

// ===== design/hecc_check.sv =====
// syndrome decode and result register
`timescale 1ns / 1ps
`default_nettype none

module hecc_check
    import hecc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  chk_valid,
    input  wire hecc_blk_t             chk_blk,
    output logic                       chk_take,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [CODE_W-1:0]          generated_code,
    output logic [STATUS_W-1:0]        check_status,
    output logic [ADDR_W-1:0]          fix_byte_address,
    output logic [BIT_W-1:0]           fix_bit_index
);

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [CODE_W-1:0]    gen_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic [STATUS_W-1:0]  status_next;
    logic [ADDR_W-1:0]    addr_reg;
    logic [ADDR_W-1:0]    addr_next;
    logic [BIT_W-1:0]     bit_reg;
    logic [BIT_W-1:0]     bit_next;

    logic [CODE_W-1:0]    syn;
    logic [CODE_W-1:0]    corr;
    logic [CODE_W-1:0]    ev;
    logic [CODE_W-1:0]    od;
    logic [ADDR_W-1:0]    od_addr;

    assign chk_take = ~out_valid_reg | ~out_stall;

    assign syn  = (chk_blk.gen ^ chk_blk.stored) & chk_blk.mask;
    assign corr = PAIR_EVEN & chk_blk.mask;
    assign ev   = syn & corr;
    assign od   = (syn >> 1) & corr;

    always_comb
    begin
        for (int j = 0; j < ADDR_W; j++)
        begin
            od_addr[j] = od[6 + 2*j];
        end
    end

    always_comb
    begin
        status_next = ST_UNCORR;
        addr_next   = '0;
        bit_next    = '0;
        priority if (syn == '0)
        begin
            status_next = ST_OK;
        end
        else if ((ev ^ od) == corr)
        begin
            // one of each pair flipped: single data bit in error
            status_next = ST_FIXED;
            addr_next   = od_addr;
            bit_next    = {od[4], od[2], od[0]};
        end
        else if ($onehot(syn))
        begin
            status_next = ST_CODE_ERR;
        end
        else
        begin
            status_next = ST_UNCORR;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (chk_take)
        begin
            out_valid_next = chk_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chk_take && chk_valid)
        begin
            gen_reg    <= chk_blk.gen;
            status_reg <= status_next;
            addr_reg   <= addr_next;
            bit_reg    <= bit_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign generated_code   = gen_reg;
    assign check_status     = status_reg;
    assign fix_byte_address = addr_reg;
    assign fix_bit_index    = bit_reg;

    a_no_fix_info: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != ST_FIXED) |-> (addr_reg == '0 && bit_reg == '0))
        else $error("fix location set without a correction");

    a_take_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (chk_valid && chk_take) |=> out_valid_reg)
        else $error("checked block not presented");

    a_ok_zero_syn: assert property (@(posedge clk) disable iff (!rst_n)
        (chk_valid && syn == '0) |-> (status_next == ST_OK))
        else $error("clean syndrome not reported as ok");

endmodule

`default_nettype wire

// ===== design/nand_hamming_ecc_engine.sv =====
// top level of the nand hamming ecc engine
//
//  channel  direction  handshake            payload
//  cfg      in         cfg_valid/cfg_ready  block_bytes_log2
//  in       in         in_valid/in_stall    data_byte, stored_code
//  out      out        out_valid/out_stall  generated_code, check_status,
//                                           fix_byte_address, fix_bit_index
//
// one byte per cycle while in_stall is low; a block of 2^k bytes gives one result on its final byte
// the result passes through the finished-block register, then the result register
// reset sets k to 9 and clears the accumulator and byte position
// in_stall rises only while a finished block waits and the result register is held by out_stall
// a configuration write clears the block in progress; cfg_ready is low while a block awaits check
`timescale 1ns / 1ps
`default_nettype none

module nand_hamming_ecc_engine
    import hecc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [LOG2_W-1:0]     block_bytes_log2,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [7:0]            data_byte,
    input  wire logic [CODE_W-1:0]     stored_code,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [CODE_W-1:0]          generated_code,
    output logic [STATUS_W-1:0]        check_status,
    output logic [ADDR_W-1:0]          fix_byte_address,
    output logic [BIT_W-1:0]           fix_bit_index
);

    logic      chk_take;
    logic      chk_valid;
    hecc_blk_t chk_blk;

    hecc_accum u_accum (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .block_bytes_log2 (block_bytes_log2),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .data_byte        (data_byte),
        .stored_code      (stored_code),
        .chk_take         (chk_take),
        .chk_valid        (chk_valid),
        .chk_blk          (chk_blk)
    );

    hecc_check u_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .chk_valid        (chk_valid),
        .chk_blk          (chk_blk),
        .chk_take         (chk_take),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .generated_code   (generated_code),
        .check_status     (check_status),
        .fix_byte_address (fix_byte_address),
        .fix_bit_index    (fix_bit_index)
    );

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// self-checking testbench for the nand hamming ecc engine
`timescale 1ns / 1ps

module tb_top;
    import hecc_pkg::*;

    typedef struct packed {
        logic [7:0]        data;
        logic [CODE_W-1:0] stored;
    } flash_beat_t;

    typedef struct packed {
        logic [CODE_W-1:0]   code;
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   addr;
        logic [BIT_W-1:0]    fix_bit;
    } ecc_report_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [LOG2_W-1:0]   block_bytes_log2 = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [7:0]          data_byte = '0;
    logic [CODE_W-1:0]   stored_code = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [CODE_W-1:0]   generated_code;
    logic [STATUS_W-1:0] check_status;
    logic [ADDR_W-1:0]   fix_byte_address;
    logic [BIT_W-1:0]    fix_bit_index;

    flash_beat_t bytes_to_send[$];
    ecc_report_t reports_due[$];

    // predictor copy of the block state
    logic [LOG2_W-1:0] sim_log2 = LOG2_W'(MAX_BLOCK_LOG2);
    logic [CODE_W-1:0] acc_par = '0;
    logic [ADDR_W-1:0] byte_pos = '0;

    int mismatches = 0;
    int send_idle_pct = 33;
    int recv_idle_pct = 49;
    bit hold_go = 1'b0;
    int hold_left = -1;
    int quiet_cycles = 0;

    nand_hamming_ecc_engine u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .block_bytes_log2 (block_bytes_log2),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .data_byte        (data_byte),
        .stored_code      (stored_code),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .generated_code   (generated_code),
        .check_status     (check_status),
        .fix_byte_address (fix_byte_address),
        .fix_bit_index    (fix_bit_index)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic int eff_log2(input logic [LOG2_W-1:0] k_raw);
        return (k_raw > MAX_BLOCK_LOG2) ? MAX_BLOCK_LOG2 : int'(k_raw);
    endfunction

    function automatic logic [CODE_W-1:0] width_mask(input int k);
        logic [31:0] m;
        m = (32'd1 << (2 * (k + 3))) - 32'd1;
        return m[CODE_W-1:0];
    endfunction

    // column parities plus the row pair members picked by the address bits
    function automatic logic [CODE_W-1:0] code_bits(input logic [7:0] d,
                                                    input logic [ADDR_W-1:0] pos,
                                                    input int k);
        logic [CODE_W-1:0] c;
        c = '0;
        c[0] = ^(d & 8'h55);
        c[1] = ^(d & 8'hAA);
        c[2] = ^(d & 8'h33);
        c[3] = ^(d & 8'hCC);
        c[4] = ^(d & 8'h0F);
        c[5] = ^(d & 8'hF0);
        for (int j = 0; j < k; j++)
        begin
            c[6 + 2 * j + int'(pos[j])] ^= ^d;
        end
        return c;
    endfunction

    function automatic bit ecc_predict(input logic [7:0] d, input logic [CODE_W-1:0] stored,
                                       output ecc_report_t rep);
        int k;
        logic [CODE_W-1:0] acc, cmask, syn, ev, od;
        k = eff_log2(sim_log2);
        acc = acc_par ^ code_bits(d, byte_pos, k);
        rep = '0;
        if (int'(byte_pos) < (1 << k) - 1)
        begin
            acc_par = acc;
            byte_pos = byte_pos + 1'b1;
            return 1'b0;
        end
        cmask = width_mask(k);
        rep.code = acc & cmask;
        rep.status = ST_OK;
        syn = (rep.code ^ stored) & cmask;
        ev = syn & PAIR_EVEN & cmask;
        od = (syn >> 1) & PAIR_EVEN & cmask;
        if (syn != '0)
        begin
            if ((ev ^ od) == (PAIR_EVEN & cmask))
            begin
                rep.status = ST_FIXED;
                rep.fix_bit = {od[4], od[2], od[0]};
                for (int j = 0; j < ADDR_W; j++)
                begin
                    rep.addr[j] = od[6 + 2 * j];
                end
            end
            else
            begin
                rep.status = ($countones(syn) == 1) ? ST_CODE_ERR : ST_UNCORR;
            end
        end
        acc_par = '0;
        byte_pos = '0;
        return 1'b1;
    endfunction

    // sender: predicts each accepted beat, then offers the next one
    always @(posedge clk or negedge rst_n)
    begin
        ecc_report_t rep;
        flash_beat_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                sim_log2 = block_bytes_log2;
                acc_par = '0;
                byte_pos = '0;
            end
            if (in_valid && !in_stall)
            begin
                if (ecc_predict(data_byte, stored_code, rep))
                    reports_due.push_back(rep);
            end
            if (!in_valid || !in_stall)
            begin
                if (bytes_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = bytes_to_send.pop_front();
                    in_valid <= 1'b1;
                    data_byte <= nxt.data;
                    stored_code <= nxt.stored;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each accepted beat and drives the stall
    always @(posedge clk or negedge rst_n)
    begin
        ecc_report_t exp_rep;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (reports_due.size() == 0)
                begin
                    $error("result beat with nothing expected: code %h status %0d",
                           generated_code, check_status);
                    mismatches++;
                end
                else
                begin
                    exp_rep = reports_due.pop_front();
                    if (generated_code !== exp_rep.code)
                    begin
                        $error("generated_code expected %h got %h", exp_rep.code,
                               generated_code);
                        mismatches++;
                    end
                    if (check_status !== exp_rep.status)
                    begin
                        $error("check_status expected %0d got %0d", exp_rep.status,
                               check_status);
                        mismatches++;
                    end
                    if (fix_byte_address !== exp_rep.addr)
                    begin
                        $error("fix_byte_address expected %0d got %0d", exp_rep.addr,
                               fix_byte_address);
                        mismatches++;
                    end
                    if (fix_bit_index !== exp_rep.fix_bit)
                    begin
                        $error("fix_bit_index expected %0d got %0d", exp_rep.fix_bit,
                               fix_bit_index);
                        mismatches++;
                    end
                end
            end
            // one long hold-off so the engine backs up into its input
            if (hold_go && hold_left < 0)
                hold_left = 300;
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= 5000)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic push_beat(input logic [7:0] d, input logic [CODE_W-1:0] stored);
        flash_beat_t beat;
        beat.data = d;
        beat.stored = stored;
        bytes_to_send.push_back(beat);
    endtask

    task automatic wait_idle();
        while (bytes_to_send.size() != 0 || in_valid || reports_due.size() != 0)
            @(posedge clk);
        // a dropped or non-final byte may still be in flight
        repeat (4) @(posedge clk);
    endtask

    task automatic write_block_log2(input logic [LOG2_W-1:0] k);
        wait_idle();
        @(posedge clk);
        cfg_valid <= 1'b1;
        block_bytes_log2 <= k;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // one block with a random error pattern folded into its stored code
    task automatic queue_block(input logic [LOG2_W-1:0] k_raw, input int fix_at);
        int k, n, kind, style, a1, a2, b1, b2;
        logic [7:0] blk[512];
        logic [CODE_W-1:0] gen, err, cmask;
        k = eff_log2(k_raw);
        n = 1 << k;
        cmask = width_mask(k);
        style = $urandom_range(9);
        gen = '0;
        for (int i = 0; i < n; i++)
        begin
            blk[i] = (style == 0) ? 8'h00 : (style == 1) ? 8'hFF : 8'($urandom());
            gen ^= code_bits(blk[i], ADDR_W'(i), k);
        end
        kind = (fix_at >= 0) ? 40 : $urandom_range(99);
        a1 = (fix_at >= 0) ? fix_at : $urandom_range(n - 1);
        a2 = $urandom_range(n - 1);
        b1 = $urandom_range(7);
        b2 = $urandom_range(7);
        if (a1 == a2 && b1 == b2)
            b2 = (b1 + 1) % 8;
        if (kind < 30)
            err = '0;
        else if (kind < 60)
            err = code_bits(8'(1 << b1), ADDR_W'(a1), k);
        else if (kind < 75)
            err = CODE_W'(1) << $urandom_range(2 * (k + 3) - 1);
        else if (kind < 88)
            err = code_bits(8'(1 << b1), ADDR_W'(a1), k)
                  ^ code_bits(8'(1 << b2), ADDR_W'(a2), k);
        else
            err = CODE_W'($urandom());
        for (int i = 0; i < n - 1; i++)
            push_beat(blk[i], CODE_W'($urandom()));
        push_beat(blk[n - 1], ((gen ^ err) & cmask) | (CODE_W'($urandom()) & ~cmask));
    endtask

    // a phase with a tail ends in a partial block and checks that reconfiguration drops it
    task automatic run_phase(input logic [LOG2_W-1:0] k, input int nblocks, input int tail,
                             input int fix_at, input bit long_hold);
        write_block_log2(k);
        if (long_hold)
            hold_go = 1'b1;
        for (int i = 0; i < nblocks; i++)
            queue_block(k, fix_at);
        for (int i = 0; i < tail; i++)
            push_beat(8'($urandom()), CODE_W'($urandom()));
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // partial block at the reset length, dropped by the first write
        for (int i = 0; i < 5; i++)
            push_beat(8'($urandom()), CODE_W'($urandom()));
        write_block_log2(4'd0);
        // single-byte blocks: every status, both data extremes, ignored upper code bits
        push_beat(8'h00, 24'h000000);
        push_beat(8'hFF, 24'hFFFFC0);
        push_beat(8'hFF, 24'h00003F);
        push_beat(8'h01, 24'h000000);
        push_beat(8'h80, 24'h000000);
        push_beat(8'h5A, code_bits(8'h5A, '0, 0) ^ 24'h000020);
        push_beat(8'h00, 24'h000003);
        write_block_log2(4'd1);
        push_beat(8'h00, 24'h5A3B00);
        push_beat(8'h10, 24'h000000);
        push_beat(8'hFF, 24'hFFFFFF);
        push_beat(8'hFF, 24'hFFFF00);

        run_phase(4'd2, 30, 3, -1, 1'b0);
        // oversized length saturates; fix lands in the upper half of the address
        run_phase(4'd15, 1, 0, 256 + $urandom_range(255), 1'b0);
        run_phase(4'd0, 80, 0, -1, 1'b1);

        send_idle_pct = 49;
        recv_idle_pct = 33;
        run_phase(4'd1, 40, 1, -1, 1'b0);
        run_phase(4'd3, 15, 5, -1, 1'b0);
        run_phase(4'd5, 3, 0, -1, 1'b0);
        run_phase(4'd9, 0, 40, -1, 1'b0);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(4'd4, 8, 0, -1, 1'b0);
        run_phase(4'd0, 60, 0, -1, 1'b0);
        run_phase(4'd6, 1, 0, -1, 1'b0);

        wait_idle();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && reports_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
